// File: rtl/core/slfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types, constants and the length rule of the sync/length frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

	// Default for the largest payload length accepted by the range rules.
	localparam int MAX_PAYLOAD_DEF = 2048;

	// Sync pair and header layout.
	localparam logic [7:0] SYNC_A      = 8'hBA;
	localparam logic [7:0] SYNC_B      = 8'h77;
	localparam logic [7:0] HDR_VERSION = 8'd1;
	localparam logic [3:0] HDR_LEN     = 4'd8;

	// Header byte positions that are kept until the header check.
	localparam int POS_VER     = 2;
	localparam int POS_TYPE    = 3;
	localparam int POS_LEN_HI  = 4;
	localparam int POS_LEN_LO  = 5;
	localparam int POS_SEQ_HI  = 6;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_MORE  = 2'd0,
		ST_READY = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// Frame type codes.
	typedef enum logic [7:0] {
		FT_01 = 8'd1,  FT_02 = 8'd2,  FT_03 = 8'd3,  FT_04 = 8'd4,
		FT_05 = 8'd5,  FT_06 = 8'd6,  FT_07 = 8'd7,  FT_08 = 8'd8,
		FT_09 = 8'd9,  FT_10 = 8'd10, FT_11 = 8'd11, FT_12 = 8'd12,
		FT_13 = 8'd13, FT_14 = 8'd14, FT_15 = 8'd15, FT_16 = 8'd16
	} frame_type_t;

	// Fixed payload lengths and range minimums of the type rules.
	localparam logic [15:0] LEN_T01     = 16'd22;
	localparam logic [15:0] LEN_T02     = 16'd7;
	localparam logic [15:0] LEN_T03_MIN = 16'd20;
	localparam logic [15:0] LEN_T04     = 16'd8;
	localparam logic [15:0] LEN_T09     = 16'd5;
	localparam logic [15:0] LEN_T10     = 16'd6;
	localparam logic [15:0] LEN_T11     = 16'd10;
	localparam logic [15:0] LEN_T12_MIN = 16'd5;
	localparam logic [15:0] LEN_T15     = 16'd6;
	localparam logic [15:0] LEN_T16     = 16'd2;
	localparam logic [15:0] LEN_EMPTY   = 16'd0;

	// Length rule for each frame type; unknown types always fail.
	function automatic logic length_ok(input logic [7:0] ftype, input logic [15:0] len,
			input logic [15:0] max_len);
		logic ok;
		begin
			case (ftype)
				FT_01: ok = (len == LEN_T01);
				FT_02: ok = (len == LEN_T02);
				FT_03: ok = (len >= LEN_T03_MIN) && (len <= max_len);
				FT_04, FT_05, FT_06: ok = (len == LEN_T04);
				FT_07, FT_08, FT_13, FT_14: ok = (len == LEN_EMPTY);
				FT_09: ok = (len == LEN_T09);
				FT_10: ok = (len == LEN_T10);
				FT_11: ok = (len == LEN_T11);
				FT_12: ok = (len >= LEN_T12_MIN) && (len <= max_len);
				FT_15: ok = (len == LEN_T15);
				FT_16: ok = (len == LEN_T16);
				default: ok = 1'b0;
			endcase
			return ok;
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/slfp_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfp_byte_if
// Input channel of the frame parser: one link byte or a parser reset per item.
// ----------------------------------------------------------------------------
interface slfp_byte_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/slfp_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfp_result_if
// Output channel of the frame parser: status, payload byte and held header.
// ----------------------------------------------------------------------------
interface slfp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [10:0] payload_index;
	logic [7:0]  frame_type;
	logic [11:0] frame_length;
	logic [15:0] frame_sequence;

	modport source (output valid, output status, output payload_valid, output payload_byte,
		output payload_index, output frame_type, output frame_length,
		output frame_sequence, input ready);
	modport sink (input valid, input status, input payload_valid, input payload_byte,
		input payload_index, input frame_type, input frame_length,
		input frame_sequence, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sync_length_frame_parser_unit.sv
`default_nettype none
// An accepted item passes through the input stage and then the result register.
// Throughput: one item per cycle while results are taken; the header counter and payload
// counter are updated in the single pass between the input stage and the result register.
// The input stage advances whenever the result register is empty or being taken.
// Reset clears the counters, the held header fields and the input and result valid flags;
// the header byte store is not reset and is only read after it has been written.
// ----------------------------------------------------------------------------
// sync_length_frame_parser_unit
// Byte-serial parser for frames with a sync pair, an eight-byte header and a
// length-prefixed payload that is streamed out with its index.
// ----------------------------------------------------------------------------
module sync_length_frame_parser_unit #(
	parameter int MAX_PAYLOAD = slfp_pkg::MAX_PAYLOAD_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	slfp_byte_if.sink     link,
	slfp_result_if.source parsed
);
	import slfp_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	// Input stage.
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	// Parser state.
	logic [3:0]       hdr_cnt_q;
	logic [LEN_W-1:0] pay_cnt_q;
	logic [7:0]       held_type_q;
	logic [LEN_W-1:0] held_len_q;
	logic [15:0]      held_seq_q;
	logic [7:0]       hdr_q [POS_VER:POS_SEQ_HI];

	// Result register.
	logic        out_valid_q;
	status_t     status_q;
	logic        pvalid_q;
	logic [7:0]  pbyte_q;
	logic [10:0] pidx_q;

	// Next-state values of the single pass.
	logic             advance;
	logic [3:0]       hdr_cnt_d;
	logic [LEN_W-1:0] pay_cnt_d;
	status_t          status_d;
	logic             pvalid_d;
	logic             store_en;
	logic             hold_en;
	logic [15:0]      hdr_len;
	logic [15:0]      hdr_seq;
	logic [LEN_W-1:0] pay_cnt_inc;
	logic [31:0]      pay_cnt_ext;
	logic [31:0]      held_len_ext;

	// Handshake: the input stage moves on when the result register can take a new item.
	assign advance    = valid_s1 && (!out_valid_q || parsed.ready);
	assign link.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (link.ready) begin
			valid_s1 <= link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link.ready && link.valid) begin
			action_s1 <= link.action;
			byte_s1   <= link.data_byte;
		end
	end

	// Header fields seen at the eighth byte; the last sequence byte is the current one.
	assign hdr_len     = {hdr_q[POS_LEN_HI], hdr_q[POS_LEN_LO]};
	assign hdr_seq     = {hdr_q[POS_SEQ_HI], byte_s1};
	assign pay_cnt_inc = pay_cnt_q + LEN_W'(1);

	// Single pass of the parser over one item.
	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		pay_cnt_d = pay_cnt_q;
		status_d  = ST_MORE;
		pvalid_d  = 1'b0;
		store_en  = 1'b0;
		hold_en   = 1'b0;
		if (action_s1) begin
			hdr_cnt_d = '0;
			pay_cnt_d = '0;
		end else if (hdr_cnt_q < HDR_LEN) begin
			if (hdr_cnt_q == 4'd0) begin
				if (byte_s1 == SYNC_A) begin
					hdr_cnt_d = 4'd1;
				end
			end else if (hdr_cnt_q == 4'd1 && byte_s1 != SYNC_B) begin
				// A repeated first sync byte keeps one byte matched.
				hdr_cnt_d = (byte_s1 == SYNC_A) ? 4'd1 : 4'd0;
			end else if (hdr_cnt_q == HDR_LEN - 4'd1) begin
				// Last header byte: check version and the type's length rule.
				if (hdr_q[POS_VER] != HDR_VERSION ||
						!length_ok(hdr_q[POS_TYPE], hdr_len, 16'(MAX_PAYLOAD))) begin
					hdr_cnt_d = '0;
					pay_cnt_d = '0;
					status_d  = ST_ERROR;
				end else begin
					hold_en = 1'b1;
					if (hdr_len == LEN_EMPTY) begin
						hdr_cnt_d = '0;
						status_d  = ST_READY;
					end else begin
						hdr_cnt_d = HDR_LEN;
					end
				end
			end else begin
				store_en  = 1'b1;
				hdr_cnt_d = hdr_cnt_q + 4'd1;
			end
		end else begin
			// Payload byte: pass it through and close the frame on the last one.
			pvalid_d = 1'b1;
			if (pay_cnt_inc == held_len_q) begin
				hdr_cnt_d = '0;
				pay_cnt_d = '0;
				status_d  = ST_READY;
			end else begin
				pay_cnt_d = pay_cnt_inc;
			end
		end
	end

	// Counters and held header fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			pay_cnt_q   <= '0;
			held_type_q <= '0;
			held_len_q  <= '0;
			held_seq_q  <= '0;
		end else if (advance) begin
			hdr_cnt_q <= hdr_cnt_d;
			pay_cnt_q <= pay_cnt_d;
			if (hold_en) begin
				held_type_q <= hdr_q[POS_TYPE];
				held_len_q  <= LEN_W'(hdr_len);
				held_seq_q  <= hdr_seq;
			end
		end
	end

	// Header byte store; only the bytes read by the header check are kept.
	always_ff @(posedge clk) begin
		if (advance && store_en && hdr_cnt_q >= 4'(POS_VER) && hdr_cnt_q <= 4'(POS_SEQ_HI)) begin
			hdr_q[hdr_cnt_q[2:0]] <= byte_s1;
		end
	end

	// Result register.
	assign pay_cnt_ext = 32'(pay_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (parsed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			pvalid_q <= pvalid_d;
			pbyte_q  <= pvalid_d ? byte_s1 : 8'd0;
			pidx_q   <= pvalid_d ? pay_cnt_ext[10:0] : 11'd0;
		end
	end

	// The held fields change only together with a result register load.
	assign held_len_ext = 32'(held_len_q);

	assign parsed.valid          = out_valid_q;
	assign parsed.status         = status_q;
	assign parsed.payload_valid  = pvalid_q;
	assign parsed.payload_byte   = pbyte_q;
	assign parsed.payload_index  = pidx_q;
	assign parsed.frame_type     = held_type_q;
	assign parsed.frame_length   = held_len_ext[11:0];
	assign parsed.frame_sequence = held_seq_q;

	// The header counter never runs past the payload phase.
	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HDR_LEN)
		else $error("header counter out of range");

	// Outside the payload phase the payload counter stays cleared.
	a_pay_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q != HDR_LEN |-> pay_cnt_q == '0)
		else $error("payload counter not cleared outside a frame");

	// In the payload phase the count stays below the held length.
	a_pay_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q == HDR_LEN |-> pay_cnt_q < held_len_q)
		else $error("payload counter reached the held length");

	// A payload byte never comes with a protocol error.
	a_payload_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pvalid_q |-> status_q != ST_ERROR)
		else $error("payload byte flagged with protocol error");

	// A stalled result keeps its held header fields.
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !parsed.ready |=> $stable(held_seq_q) && $stable(held_type_q))
		else $error("held header changed under a stalled item");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length frame parser. A short table of
// directed bytes comes first, then a long stream of random frames. The stream
// mixes good frames, broken headers, cut frames and line noise. Every result
// item is compared with the directed table's expected value or with a behavioral
// predictor that runs on each accepted input item.
// ----------------------------------------------------------------------------
module tb_top;
	import slfp_pkg::*;

	localparam int MAX_LEN       = MAX_PAYLOAD_DEF;
	localparam int HDR_BYTES     = int'(HDR_LEN);
	localparam int DIR_ROWS      = 25;
	localparam int RANDOM_ITEMS  = 1850;
	localparam int STIM_BUDGET   = DIR_ROWS + RANDOM_ITEMS;
	localparam int LONGEST_AT    = 1000;
	localparam int SHORT_LEN_TOP = 40;
	localparam int LONG_LEN_TOP  = 300;
	localparam int MAX_REPORTS   = 10;
	localparam int DRAIN_CYCLES  = 8;

	// One result item of the parser.
	typedef struct packed {
		status_t     status;
		logic        pv;
		logic [7:0]  pbyte;
		logic [10:0] pidx;
		logic [7:0]  ftype;
		logic [11:0] flen;
		logic [15:0] fseq;
	} parse_result_t;

	// One row of the directed table; want is used only when typed is set.
	typedef struct packed {
		logic          act;
		logic [7:0]    b;
		logic          typed;
		parse_result_t want;
	} stim_row_t;

	typedef enum int {FAULT_VERSION, FAULT_TYPE, FAULT_LENGTH} hdr_fault_t;
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	localparam parse_result_t UNTYPED = '0;

	logic clk;
	logic arst_n;

	slfp_byte_if   link_if ();
	slfp_result_if res_if ();

	sync_length_frame_parser_unit #(
		.MAX_PAYLOAD(MAX_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.link  (link_if),
		.parsed(res_if)
	);

	// Predictor state of the parser.
	logic [7:0]  hdr_buf [0:7];
	int          hdr_cnt;
	int          pay_cnt;
	logic [7:0]  held_type;
	logic [15:0] held_len;
	logic [15:0] held_seq;

	// Results still owed by the block, oldest first.
	parse_result_t owed_results [$];

	// Run bookkeeping.
	int  fed_count;
	int  results_seen;
	int  mismatches;
	int  frames_done;
	int  hdr_errors;
	int  payload_seen;
	int  parser_resets;
	int  longest_frame;
	int  burst_left;
	bit  rx_hold;

	// Directed bytes: reset action, a repeated sync byte, a bad version, a short
	// frame with its payload, and a parser reset in the middle of a header.
	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{1'b1, 8'hFF, 1'b1, '{ST_MORE, 1'b0, 8'h00, 11'd0, 8'h00, 12'd0, 16'h0000}},
		'{1'b0, 8'h00, 1'b0, UNTYPED},
		'{1'b0, SYNC_A, 1'b0, UNTYPED},
		'{1'b0, SYNC_A, 1'b0, UNTYPED},
		'{1'b0, SYNC_B, 1'b0, UNTYPED},
		'{1'b0, 8'h00, 1'b0, UNTYPED},
		'{1'b0, FT_07, 1'b0, UNTYPED},
		'{1'b0, 8'h00, 1'b0, UNTYPED},
		'{1'b0, 8'h00, 1'b0, UNTYPED},
		'{1'b0, 8'hFF, 1'b0, UNTYPED},
		'{1'b0, 8'hFF, 1'b1, '{ST_ERROR, 1'b0, 8'h00, 11'd0, 8'h00, 12'd0, 16'h0000}},
		'{1'b0, SYNC_A, 1'b0, UNTYPED},
		'{1'b0, SYNC_B, 1'b0, UNTYPED},
		'{1'b0, HDR_VERSION, 1'b0, UNTYPED},
		'{1'b0, FT_16, 1'b0, UNTYPED},
		'{1'b0, 8'h00, 1'b0, UNTYPED},
		'{1'b0, 8'h02, 1'b0, UNTYPED},
		'{1'b0, 8'hFF, 1'b0, UNTYPED},
		'{1'b0, 8'h00, 1'b0, UNTYPED},
		'{1'b0, 8'h80, 1'b1, '{ST_MORE, 1'b1, 8'h80, 11'd0, FT_16, 12'd2, 16'hFF00}},
		'{1'b0, 8'h7F, 1'b1, '{ST_READY, 1'b1, 8'h7F, 11'd1, FT_16, 12'd2, 16'hFF00}},
		'{1'b0, SYNC_A, 1'b0, UNTYPED},
		'{1'b0, SYNC_B, 1'b0, UNTYPED},
		'{1'b1, 8'h55, 1'b1, '{ST_MORE, 1'b0, 8'h00, 11'd0, FT_16, 12'd2, 16'hFF00}},
		'{1'b0, SYNC_B, 1'b1, '{ST_MORE, 1'b0, 8'h00, 11'd0, FT_16, 12'd2, 16'hFF00}}
	};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("sync_length_frame_parser_unit regression: fail");
		$finish;
	end

	// A length that passes the rule for a known type; range types mostly short.
	function automatic logic [15:0] legal_len(input logic [7:0] ftype);
		case (ftype)
			FT_01: return LEN_T01;
			FT_02: return LEN_T02;
			FT_03: begin
				if ($urandom_range(0, 7) == 0)
					return 16'($urandom_range(LEN_T03_MIN, LONG_LEN_TOP));
				return 16'($urandom_range(LEN_T03_MIN, SHORT_LEN_TOP));
			end
			FT_04, FT_05, FT_06: return LEN_T04;
			FT_07, FT_08, FT_13, FT_14: return LEN_EMPTY;
			FT_09: return LEN_T09;
			FT_10: return LEN_T10;
			FT_11: return LEN_T11;
			FT_12: return 16'($urandom_range(LEN_T12_MIN, SHORT_LEN_TOP));
			FT_15: return LEN_T15;
			FT_16: return LEN_T16;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Header length check: ranges for the two open types, a fixed value otherwise.
	function automatic bit frame_len_legal(input logic [7:0] ftype, input logic [15:0] len);
		case (ftype)
			FT_03: return len >= LEN_T03_MIN && len <= MAX_LEN;
			FT_12: return len >= LEN_T12_MIN && len <= MAX_LEN;
			default: return ftype >= FT_01 && ftype <= FT_16 && len == legal_len(ftype);
		endcase
	endfunction

	// Advance the predictor by one input item and return the result it causes.
	function automatic parse_result_t parse_byte(input logic act, input logic [7:0] b);
		parse_result_t r;
		logic [15:0]   len;
		bit            done;
		r = '0;
		r.status = ST_MORE;
		done = 1'b0;
		if (act) begin
			hdr_cnt = 0;
			pay_cnt = 0;
		end else if (hdr_cnt < HDR_BYTES) begin
			if (hdr_cnt == 0) begin
				if (b == SYNC_A) begin
					hdr_buf[0] = b;
					hdr_cnt = 1;
				end
			end else if (hdr_cnt == 1 && b != SYNC_B) begin
				// A second sync byte keeps the hunt one byte in.
				hdr_cnt = (b == SYNC_A) ? 1 : 0;
			end else begin
				hdr_buf[hdr_cnt] = b;
				hdr_cnt++;
				if (hdr_cnt == HDR_BYTES) begin
					len = {hdr_buf[POS_LEN_HI], hdr_buf[POS_LEN_LO]};
					if (hdr_buf[POS_VER] != HDR_VERSION ||
							!frame_len_legal(hdr_buf[POS_TYPE], len)) begin
						hdr_cnt = 0;
						pay_cnt = 0;
						r.status = ST_ERROR;
					end else begin
						held_type = hdr_buf[POS_TYPE];
						held_len = len;
						held_seq = {hdr_buf[POS_SEQ_HI], hdr_buf[POS_SEQ_HI + 1]};
						done = 1'b1;
					end
				end
			end
		end else begin
			r.pv = 1'b1;
			r.pbyte = b;
			r.pidx = pay_cnt[10:0];
			pay_cnt++;
			done = 1'b1;
		end
		// The frame closes on its last payload byte, or on the header if empty.
		if (done && hdr_cnt == HDR_BYTES && pay_cnt == held_len) begin
			r.status = ST_READY;
			hdr_cnt = 0;
			pay_cnt = 0;
		end
		r.ftype = held_type;
		r.flen = held_len[11:0];
		r.fseq = held_seq;
		return r;
	endfunction

	// Offer one item in bursts with random gaps, then log its expected result.
	task automatic send_item(input logic act, input logic [7:0] b, input logic typed,
			input parse_result_t want);
		parse_result_t p;
		int            gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				link_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		link_if.valid <= 1'b1;
		link_if.action <= act;
		link_if.data_byte <= b;
		do @(negedge clk); while (!link_if.ready);
		@(posedge clk);
		p = parse_byte(act, b);
		owed_results.push_back(typed ? want : p);
		fed_count++;
		parser_resets += int'(act);
		payload_seen += int'(p.pv);
		if (p.status == ST_ERROR)
			hdr_errors++;
		if (p.status == ST_READY) begin
			frames_done++;
			if (int'(held_len) > longest_frame)
				longest_frame = int'(held_len);
		end
	endtask

	task automatic feed(input logic [7:0] b);
		send_item(1'b0, b, 1'b0, UNTYPED);
	endtask

	// Send the first nbytes of a header.
	task automatic send_header(input logic [7:0] ver, input logic [7:0] ftype,
			input logic [15:0] len, input logic [15:0] seq, input int nbytes);
		logic [7:0] hb [0:7];
		hb = '{SYNC_A, SYNC_B, ver, ftype, len[15:8], len[7:0], seq[15:8], seq[7:0]};
		for (int i = 0; i < nbytes; i++)
			feed(hb[i]);
	endtask

	// A well-formed frame, sometimes led by stray bytes that keep the hunt going.
	task automatic send_good_frame(input bit longest);
		logic [7:0]  ftype;
		logic [15:0] len;
		logic [7:0]  b;
		ftype = 8'($urandom_range(FT_01, FT_16));
		len = legal_len(ftype);
		if (longest) begin
			// Header of the largest legal length; the frame is cut after a few bytes.
			send_header(HDR_VERSION, FT_03, 16'(MAX_LEN), 16'($urandom), HDR_BYTES);
			repeat ($urandom_range(1, 8))
				feed(8'($urandom));
			send_item(1'b1, 8'($urandom), 1'b0, UNTYPED);
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom_range(0, 255));
					feed(($urandom_range(0, 1) == 0 || b == SYNC_A) ? SYNC_A : b);
				end
			end
			send_header(HDR_VERSION, ftype, len, 16'($urandom), HDR_BYTES);
			for (int i = 0; i < len; i++)
				feed(8'($urandom));
		end
	endtask

	// A full header that breaks the version, type or length rule.
	task automatic send_bad_header();
		hdr_fault_t  fault;
		logic [7:0]  ver;
		logic [7:0]  ftype;
		logic [15:0] len;
		fault = hdr_fault_t'($urandom_range(0, 2));
		ver = HDR_VERSION;
		ftype = 8'($urandom_range(FT_01, FT_16));
		len = legal_len(ftype);
		case (fault)
			FAULT_VERSION: begin
				do ver = 8'($urandom); while (ver == HDR_VERSION);
			end
			FAULT_TYPE: begin
				do ftype = 8'($urandom); while (ftype >= FT_01 && ftype <= FT_16);
				len = 16'($urandom);
			end
			default: begin
				len = 16'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					ftype = ($urandom_range(0, 1) == 0) ? FT_03 : FT_12;
					len = 16'(MAX_LEN + 1);
				end
				if (frame_len_legal(ftype, len))
					len = len ^ 16'h8000;
			end
		endcase
		send_header(ver, ftype, len, 16'($urandom), HDR_BYTES);
	endtask

	// A good frame cut short by a parser reset.
	task automatic send_cut_frame();
		logic [7:0]  ftype;
		logic [15:0] len;
		int          n;
		ftype = 8'($urandom_range(FT_01, FT_16));
		len = legal_len(ftype);
		n = $urandom_range(1, HDR_BYTES + len - 1);
		send_header(HDR_VERSION, ftype, len, 16'($urandom), (n < HDR_BYTES) ? n : HDR_BYTES);
		for (int i = HDR_BYTES; i < n; i++)
			feed(8'($urandom));
		send_item(1'b1, 8'($urandom), 1'b0, UNTYPED);
	endtask

	// Line noise rich in sync bytes, often followed by a parser reset.
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: b = SYNC_A;
				4: b = SYNC_B;
				default: b = 8'($urandom);
			endcase
			feed(b);
		end
		if ($urandom_range(0, 1) == 1)
			send_item(1'b1, 8'($urandom), 1'b0, UNTYPED);
	endtask

	task automatic report_mismatch(input string what, input parse_result_t want,
			input parse_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("ERROR result %0d (%s): expected st=%0d pv=%0d byte=%02h idx=%0d %s",
				results_seen, what, want.status, want.pv, want.pbyte, want.pidx,
				$sformatf("type=%0d len=%0d seq=%04h", want.ftype, want.flen, want.fseq));
			$display("    got st=%0d pv=%0d byte=%02h idx=%0d type=%0d len=%0d seq=%04h",
				got.status, got.pv, got.pbyte, got.pidx, got.ftype, got.flen, got.fseq);
		end
	endtask

	// Compare one result item with the oldest one owed.
	task automatic check_result(input parse_result_t got);
		parse_result_t want;
		string         which;
		results_seen++;
		if (owed_results.size() == 0) begin
			report_mismatch("nothing expected", UNTYPED, got);
		end else begin
			want = owed_results.pop_front();
			which = "";
			if (got.status !== want.status) which = {which, " status"};
			if (got.pv !== want.pv) which = {which, " payload_valid"};
			if (got.pbyte !== want.pbyte) which = {which, " payload_byte"};
			if (got.pidx !== want.pidx) which = {which, " payload_index"};
			if (got.ftype !== want.ftype) which = {which, " frame_type"};
			if (got.flen !== want.flen) which = {which, " frame_length"};
			if (got.fseq !== want.fseq) which = {which, " frame_sequence"};
			if (which != "")
				report_mismatch({"bad", which}, want, got);
		end
	endtask

	// Result monitor: handshake signals are stable at the falling edge.
	initial begin : result_monitor
		parse_result_t got;
		forever begin
			@(negedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				got = '{status_t'(res_if.status), res_if.payload_valid, res_if.payload_byte,
					res_if.payload_index, res_if.frame_type, res_if.frame_length,
					res_if.frame_sequence};
				check_result(got);
			end
		end
	end

	// Receiver: stall pattern drawn at random among free, light, heavy and periodic modes.
	initial begin : rx_pattern
		rx_mode_t mode;
		int       left;
		int       phase;
		bit       rdy;
		res_if.ready = 1'b0;
		mode = RX_FREE;
		left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(64, 256);
			end
			left--;
			phase++;
			case (mode)
				RX_FREE: rdy = 1'b1;
				RX_LIGHT: rdy = ($urandom_range(0, 3) != 0);
				RX_HEAVY: rdy = ($urandom_range(0, 2) == 0);
				default: rdy = (phase % 7 < 4);
			endcase
			res_if.ready <= rdy && !rx_hold;
		end
	end

	// Long receiver hold-offs while the sender keeps offering items.
	initial begin : rx_backpressure
		rx_hold = 1'b0;
		while (fed_count < 300) @(negedge clk);
		rx_hold = 1'b1;
		repeat (400) @(negedge clk);
		rx_hold = 1'b0;
		while (fed_count < 1300) @(negedge clk);
		rx_hold = 1'b1;
		repeat (250) @(negedge clk);
		rx_hold = 1'b0;
	end

	// Reset, directed table, random frames, drain and verdict.
	initial begin : stimulus
		int roll;
		bit longest_sent;
		arst_n = 1'b0;
		link_if.valid = 1'b0;
		link_if.action = 1'b0;
		link_if.data_byte = 8'h00;
		hdr_cnt = 0;
		pay_cnt = 0;
		held_type = '0;
		held_len = '0;
		held_seq = '0;
		fed_count = 0;
		results_seen = 0;
		mismatches = 0;
		frames_done = 0;
		hdr_errors = 0;
		payload_seen = 0;
		parser_resets = 0;
		longest_frame = 0;
		burst_left = 0;
		longest_sent = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows.
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].act, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

		// Random stream, mostly good frames; one header of the largest length.
		while (fed_count < STIM_BUDGET) begin
			roll = $urandom_range(0, 99);
			if (!longest_sent && fed_count >= LONGEST_AT) begin
				send_good_frame(1'b1);
				longest_sent = 1'b1;
			end else if (roll < 65) begin
				send_good_frame(1'b0);
			end else if (roll < 77) begin
				send_bad_header();
			end else if (roll < 87) begin
				send_cut_frame();
			end else begin
				send_noise();
			end
		end
		link_if.valid <= 1'b0;

		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d items and checked %0d results: %0d frames closed, %0d header errors.",
			fed_count, results_seen, frames_done, hdr_errors);
		$display("Streamed %0d payload bytes (longest frame %0d), %0d parser resets.",
			payload_seen, longest_frame, parser_resets);
		$display("Mismatches: %0d.", mismatches);
		if (mismatches == 0) begin
			$display("sync_length_frame_parser_unit regression: pass");
		end else begin
			$display("sync_length_frame_parser_unit regression: fail");
		end
		$finish;
	end

endmodule
